// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the keyed table modules.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge.
`define KT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication from a trigger condition.
`define KT_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ----- rtl/ktisr_pkg.sv -----
package ktisr_pkg;

    localparam int CAPACITY_DEF   = 10;
    localparam int KEY_BYTES_DEF  = 8;
    localparam int KIND_BYTES_DEF = 8;

    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int KEY_W  = 64;
    localparam int KIND_W = 64;
    localparam int AMT_W  = 32;
    localparam int POS_W  = 4;

    localparam int IN_TDATA_W  = ((KEY_W + KIND_W + AMT_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = KEY_W + KIND_W + AMT_W + POS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_LIST   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // Read address selection for the entry memory.
    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_IDX  = 2'd1,
        RD_IDX1 = 2'd2,
        RD_IDX2 = 2'd3
    } t_rd_sel;

    typedef enum logic {
        WR_AT_COUNT = 1'b0,
        WR_AT_IDX   = 1'b1
    } t_wr_sel;

    // What the result register is loaded from.
    typedef enum logic [1:0] {
        OUT_NONE  = 2'd0,
        OUT_ITEM  = 2'd1,
        OUT_ENTRY = 2'd2
    } t_out_src;

    typedef struct packed {
        logic [KEY_W-1:0]        name;
        logic [KIND_W-1:0]       kind;
        logic signed [AMT_W-1:0] amount;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        t_rd_sel  rd_sel;
        logic     idx_clr;
        logic     idx_inc;
        logic     wr_en;
        t_wr_sel  wr_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     out_load;
        t_out_src out_src;
        t_status  out_status;
        logic     out_last;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic empty;
        logic match;
        logic idx_last;
        logic shift_more;
        logic out_free;
    } t_dp_stat;

    // Keeps the low 'bytes' bytes of a 64-bit key.
    function automatic logic [63:0] byte_mask(input int bytes);
        logic [63:0] mask;
        mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < bytes) begin
                mask[8*b +: 8] = 8'hFF;
            end
        end
        return mask;
    endfunction

endpackage

// ----- rtl/ktisr_datapath.sv -----
`include "assert_macros.svh"

module ktisr_datapath #(
    parameter int CAPACITY   = ktisr_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES  = ktisr_pkg::KEY_BYTES_DEF,
    parameter int KIND_BYTES = ktisr_pkg::KIND_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ktisr_pkg::t_cmd                   i_command,
    input  logic [ktisr_pkg::KEY_W-1:0]       i_item_name,
    input  logic [ktisr_pkg::KIND_W-1:0]      i_item_kind,
    input  logic signed [ktisr_pkg::AMT_W-1:0] i_item_amount,
    input  ktisr_pkg::t_dp_cmd                i_ctl,
    output ktisr_pkg::t_dp_stat               o_stat,
    input  logic                              i_ready,
    output logic                              o_valid,
    output ktisr_pkg::t_status                o_status,
    output logic [ktisr_pkg::KEY_W-1:0]       o_found_name,
    output logic [ktisr_pkg::KIND_W-1:0]      o_found_kind,
    output logic signed [ktisr_pkg::AMT_W-1:0] o_found_amount,
    output logic [ktisr_pkg::POS_W-1:0]       o_position,
    output logic                              o_last_of_run
);
    import ktisr_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [KEY_W-1:0]  NAME_MASK = byte_mask(KEY_BYTES);
    localparam logic [KIND_W-1:0] KIND_MASK = byte_mask(KIND_BYTES);

    t_entry                  r_mem [CAPACITY];
    t_entry                  r_rd;
    t_cmd                    r_cmd;
    logic [KEY_W-1:0]        r_name;
    logic [KIND_W-1:0]       r_kind;
    logic signed [AMT_W-1:0] r_amount;
    logic [CW-1:0]           r_count;
    logic [AW-1:0]           r_idx;
    logic                    r_out_valid;
    t_status                 r_out_status;
    t_entry                  r_out_entry;
    logic [POS_W-1:0]        r_out_pos;
    logic                    r_out_last;

    logic [AW-1:0]      w_rd_addr;
    logic [AW-1:0]      w_wr_addr;
    t_entry             w_wr_data;
    logic [CW:0]        w_idx_x;
    logic [CW:0]        w_count_x;
    logic [AW+POS_W-1:0] w_idx_pos;
    logic [CW+POS_W-1:0] w_cnt_pos;
    logic               w_out_free;

    assign w_idx_x   = (CW+1)'(r_idx);
    assign w_count_x = {1'b0, r_count};
    assign w_idx_pos = (AW+POS_W)'(r_idx);
    assign w_cnt_pos = (CW+POS_W)'(r_count);
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        case (i_ctl.rd_sel)
            RD_ZERO: w_rd_addr = '0;
            RD_IDX:  w_rd_addr = r_idx;
            RD_IDX1: w_rd_addr = r_idx + AW'(1);
            RD_IDX2: w_rd_addr = r_idx + AW'(2);
            default: w_rd_addr = r_idx;
        endcase
    end

    always_comb begin
        if (i_ctl.wr_sel == WR_AT_COUNT) begin
            w_wr_addr = r_count[AW-1:0];
            w_wr_data = '{name: r_name, kind: r_kind, amount: r_amount};
        end else begin
            w_wr_addr = r_idx;
            w_wr_data = r_rd;
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.full       = (r_count >= CAP_C);
        o_stat.empty      = (r_count == '0);
        o_stat.match      = (r_rd.name == r_name);
        o_stat.idx_last   = ((w_idx_x + (CW+1)'(1)) >= w_count_x);
        o_stat.shift_more = ((w_idx_x + (CW+1)'(2)) < w_count_x);
        o_stat.out_free   = w_out_free;
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd    <= i_command;
            r_name   <= i_item_name & NAME_MASK;
            r_kind   <= i_item_kind & KIND_MASK;
            r_amount <= i_item_amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_ctl.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_ctl.idx_clr) begin
                r_idx <= '0;
            end else if (i_ctl.idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_status <= i_ctl.out_status;
            r_out_last   <= i_ctl.out_last;
            case (i_ctl.out_src)
                OUT_ITEM: begin
                    r_out_entry <= '{name: r_name, kind: r_kind, amount: r_amount};
                    r_out_pos   <= w_cnt_pos[POS_W-1:0];
                end
                OUT_ENTRY: begin
                    r_out_entry <= r_rd;
                    r_out_pos   <= w_idx_pos[POS_W-1:0];
                end
                default: begin
                    r_out_entry <= '0;
                    r_out_pos   <= '0;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found_name   = r_out_entry.name;
    assign o_found_kind   = r_out_entry.kind;
    assign o_found_amount = r_out_entry.amount;
    assign o_position     = r_out_pos;
    assign o_last_of_run  = r_out_last;

    `KT_ASSERT(a_count_range, r_count <= CAP_C, "entry count beyond capacity")
    `KT_ASSERT_IMPL(a_no_overrun, i_ctl.out_load, w_out_free, "result overwritten before taken")
    `KT_ASSERT_IMPL(a_insert_room, i_ctl.wr_en && i_ctl.wr_sel == WR_AT_COUNT,
        r_count < CAP_C, "append into a full table")
    `KT_ASSERT_IMPL(a_count_dec, i_ctl.cnt_dec, r_count != '0, "removal from an empty table")

endmodule

// ----- rtl/ktisr_ctrl.sv -----
`include "assert_macros.svh"

module ktisr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ktisr_pkg::t_dp_stat i_stat,
    output ktisr_pkg::t_dp_cmd  o_cmd
);
    import ktisr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_LIST,
        S_SHIFT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd.capture    = 1'b0;
        o_cmd.rd_sel     = RD_IDX;
        o_cmd.idx_clr    = 1'b0;
        o_cmd.idx_inc    = 1'b0;
        o_cmd.wr_en      = 1'b0;
        o_cmd.wr_sel     = WR_AT_COUNT;
        o_cmd.cnt_inc    = 1'b0;
        o_cmd.cnt_dec    = 1'b0;
        o_cmd.out_load   = 1'b0;
        o_cmd.out_src    = OUT_NONE;
        o_cmd.out_status = ST_OK;
        o_cmd.out_last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.cmd)
                    CMD_INSERT: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.wr_en   = 1'b1;
                                o_cmd.out_src = OUT_ITEM;
                                o_cmd.cnt_inc = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    CMD_LIST: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                                n_state = S_IDLE;
                            end
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            o_cmd.rd_sel  = RD_ZERO;
                            n_state = S_LIST;
                        end
                    end
                    default: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_MISSING;
                                n_state = S_IDLE;
                            end
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            o_cmd.rd_sel  = RD_ZERO;
                            n_state = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_src  = OUT_ENTRY;
                        if (i_stat.cmd == CMD_REMOVE) begin
                            if (i_stat.idx_last) begin
                                o_cmd.cnt_dec = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                o_cmd.rd_sel = RD_IDX1;
                                n_state = S_SHIFT;
                            end
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (i_stat.idx_last) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = ST_MISSING;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_sel  = RD_IDX1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_LIST: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = OUT_ENTRY;
                    o_cmd.out_last = i_stat.idx_last;
                    if (i_stat.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_sel  = RD_IDX1;
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                // The read register holds the entry one slot above the index.
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_AT_IDX;
                if (i_stat.shift_more) begin
                    o_cmd.rd_sel  = RD_IDX2;
                    o_cmd.idx_inc = 1'b1;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `KT_ASSERT_IMPL(a_shift_only_remove, r_state == S_SHIFT, i_stat.cmd == CMD_REMOVE,
        "entry shift outside a remove")

endmodule

// ----- rtl/keyed_table_insert_search_remove.sv -----
// Keyed table with insert, remove, search and list commands.
//
// Commands enter as beats on the s_axis channel: the operation code rides in
// tuser, the name key, kind tag and signed amount ride in tdata.  Results leave
// as beats on the m_axis channel with the status code in tuser and tlast set on
// the final result of each command.  Every command yields exactly one result,
// except list of a non-empty table: one result per stored entry in slot order.
//
// One command is processed at a time; s_axis_tready is high only while the
// controller is idle.  Insert appends the item unless the table is full.
// Search and remove compare entries in slot order until a match or the end of
// the table; remove then shifts every entry behind the removed slot down by
// one.  List reads the entries in slot order.  The entry memory has one write
// and one registered read port and delivers one entry per cycle; the list walk
// and a match wait while the result register is still held by the receiver.
//
// Reset empties the table; entry storage itself is not cleared.
// A result register sits on m_axis; while the receiver stalls, the result is
// held and the controller waits before producing the next one.
module keyed_table_insert_search_remove #(
    parameter int CAPACITY   = ktisr_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES  = ktisr_pkg::KEY_BYTES_DEF,
    parameter int KIND_BYTES = ktisr_pkg::KIND_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // item_name [63:0], item_kind [127:64], item_amount [159:128]
    input  logic [ktisr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // command [1:0]
    input  logic [ktisr_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // found_name [63:0], found_kind [127:64], found_amount [159:128],
    // position [163:160], zero fill above
    output logic [ktisr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // status [1:0]
    output logic [ktisr_pkg::STAT_W-1:0]        m_axis_tuser,
    output logic                                m_axis_tlast
);
    import ktisr_pkg::*;

    localparam int OUT_PAD = OUT_TDATA_W - OUT_FIELD_W;

    t_dp_cmd                 w_cmd;
    t_dp_stat                w_stat;
    t_status                 w_status;
    logic [KEY_W-1:0]        w_found_name;
    logic [KIND_W-1:0]       w_found_kind;
    logic signed [AMT_W-1:0] w_found_amount;
    logic [POS_W-1:0]        w_position;

    // Controller: sequences each command over the datapath.
    ktisr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: entry memory, count, scan index and the result register.
    ktisr_datapath #(
        .CAPACITY   (CAPACITY),
        .KEY_BYTES  (KEY_BYTES),
        .KIND_BYTES (KIND_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (t_cmd'(s_axis_tuser)),
        .i_item_name    (s_axis_tdata[KEY_W-1:0]),
        .i_item_kind    (s_axis_tdata[KEY_W+KIND_W-1:KEY_W]),
        .i_item_amount  (s_axis_tdata[KEY_W+KIND_W+AMT_W-1:KEY_W+KIND_W]),
        .i_ctl          (w_cmd),
        .o_stat         (w_stat),
        .i_ready        (m_axis_tready),
        .o_valid        (m_axis_tvalid),
        .o_status       (w_status),
        .o_found_name   (w_found_name),
        .o_found_kind   (w_found_kind),
        .o_found_amount (w_found_amount),
        .o_position     (w_position),
        .o_last_of_run  (m_axis_tlast)
    );

    assign m_axis_tuser = w_status;
    assign m_axis_tdata = {{OUT_PAD{1'b0}}, w_position, w_found_amount,
                           w_found_kind, w_found_name};

endmodule
